>>> rtl/core/acrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acknowledged record log package
// Shared types, operation and result codes for the record log core.
// ----------------------------------------------------------------------------
package acrl_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = $clog2(SLOTS);

    localparam logic [2:0] OP_STORE   = 3'd0;
    localparam logic [2:0] OP_UPLOAD  = 3'd1;
    localparam logic [2:0] OP_CONFIRM = 3'd2;
    localparam logic [2:0] OP_STATS   = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [2:0] KIND_STORE_ACK   = 3'd0;
    localparam logic [2:0] KIND_SENT        = 3'd1;
    localparam logic [2:0] KIND_UPLOAD_DONE = 3'd2;
    localparam logic [2:0] KIND_CONFIRM_ACK = 3'd3;
    localparam logic [2:0] KIND_STATS       = 3'd4;
    localparam logic [2:0] KIND_CLEAR_DONE  = 3'd5;

    localparam logic [3:0] BATCH_RESET = 4'd10;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] stamp;
        logic [63:0] record_payload;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] out_stamp;
        logic [63:0] out_payload;
        logic        dropped_oldest;
        logic        found;
        logic [3:0]  sent_count;
        logic [5:0]  used_slots;
        logic [5:0]  pending_records;
        logic [6:0]  free_records;
        logic [31:0] total_stored;
        logic        last;
    } t_out_item;

    // Write port request for the record store.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [31:0]       stamp;
        logic [63:0]       payload;
        logic              we_marks;
        logic              sent;
        logic              conf;
    } t_mem_wr;

    typedef struct packed {
        logic [31:0] stamp;
        logic [63:0] payload;
        logic        sent;
        logic        conf;
    } t_mem_rd;

endpackage

>>> rtl/core/acrl_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record store
// Synchronous record memory with one write and one registered read port.
// ----------------------------------------------------------------------------
module acrl_store import acrl_pkg::*; (
    input  logic              i_clk,
    input  t_mem_wr           i_wr,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output t_mem_rd           o_rd
);

    logic [95:0] r_data [SLOTS];
    logic [1:0]  r_marks [SLOTS];
    logic [95:0] r_rd_data;
    logic [1:0]  r_rd_marks;

    // Marks live in their own array so a mark update keeps the record body.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_data[i_wr.addr] <= {i_wr.stamp, i_wr.payload};
        end
        if (i_wr.we_marks) begin
            r_marks[i_wr.addr] <= {i_wr.sent, i_wr.conf};
        end
        r_rd_data  <= r_data[i_rd_addr];
        r_rd_marks <= r_marks[i_rd_addr];
    end

    assign o_rd.stamp   = r_rd_data[95:64];
    assign o_rd.payload = r_rd_data[63:0];
    assign o_rd.sent    = r_rd_marks[1];
    assign o_rd.conf    = r_rd_marks[0];

endmodule

>>> rtl/core/acked_circular_record_log_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acknowledged circular record log core
// Ring of record slots with upload batching and confirm-driven retirement.
// ----------------------------------------------------------------------------
// The input channel (i_in_valid, o_in_stall, i_in_item) carries operations:
// store, upload, confirm, stats and clear. The output channel (o_out_valid,
// i_out_stall, o_out_item) returns result items; the final item of each
// operation has last set. Unknown operations give no result.
// The block works on one operation at a time and stalls its input until all
// results of the current one have been taken.
// Store and clear give their item in the cycle after acceptance, and the next
// item can be accepted then if the receiver is not stalling.
// Upload, confirm and stats walk the window through the single read port of
// the record memory, addressing each slot and then evaluating it; upload
// and stats give their closing item when the walk ends. Confirm then walks
// again from the oldest end to retire confirmed records.
// When the receiver stalls, the output register holds its item and an upload
// walk or closing item waits until it is taken, so nothing is lost or repeated.
// Reset empties the ring and sets the batch limit to ten; the memory is not
// cleared since only slots written by store are ever read. The user must
// write the batch limit via i_cfg_we / i_cfg_data only while idle (unchecked).
// ----------------------------------------------------------------------------
module acked_circular_record_log_core import acrl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;  // read issued, data next cycle
    localparam logic [2:0] ST_EVAL = 3'd2;  // read data valid
    localparam logic [2:0] ST_RET  = 3'd3;  // retirement read issued
    localparam logic [2:0] ST_RETE = 3'd4;  // retirement data valid
    localparam logic [2:0] ST_FIN  = 3'd5;  // emit the closing item

    logic [2:0]        r_state, n_state;
    logic [3:0]        r_batch;
    logic [SLOT_W-1:0] r_wr_slot, n_wr_slot;
    logic [SLOT_W-1:0] r_old_slot, n_old_slot;
    logic [31:0]       r_total, n_total;
    t_in_item          r_cmd, n_cmd;
    logic [SLOT_W-1:0] r_ptr, n_ptr;
    logic [3:0]        r_cnt, n_cnt;
    logic [SLOT_W:0]   r_used, n_used;
    logic [SLOT_W:0]   r_pend, n_pend;
    logic              r_found, n_found;
    logic              r_ovalid, n_ovalid;
    t_out_item         r_oitem, n_oitem;

    t_mem_wr           s_wr;
    logic [SLOT_W-1:0] s_rd_addr;
    t_mem_rd           s_rd;
    logic              s_out_free;
    logic              s_accept;
    logic [SLOT_W-1:0] s_wr_next;
    logic [SLOT_W-1:0] s_ptr_next;
    t_out_item         s_blank;

    acrl_store u_store (
        .i_clk     (i_clk),
        .i_wr      (s_wr),
        .i_rd_addr (s_rd_addr),
        .o_rd      (s_rd)
    );

    assign s_out_free = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !s_out_free;
    assign s_accept   = i_in_valid && !o_in_stall;
    assign s_wr_next  = (r_wr_slot == SLOTS[SLOT_W-1:0] - 1'b1) ? '0 : r_wr_slot + 1'b1;
    assign s_ptr_next = (r_ptr == SLOTS[SLOT_W-1:0] - 1'b1) ? '0 : r_ptr + 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

    always_comb begin
        s_blank = '0;
        n_state = r_state;
        n_wr_slot = r_wr_slot;
        n_old_slot = r_old_slot;
        n_total = r_total;
        n_cmd = r_cmd;
        n_ptr = r_ptr;
        n_cnt = r_cnt;
        n_used = r_used;
        n_pend = r_pend;
        n_found = r_found;
        n_ovalid = r_ovalid && i_out_stall;
        n_oitem = r_oitem;
        s_wr = '0;
        s_wr.addr = r_ptr;
        s_rd_addr = r_ptr;

        case (r_state)
            ST_IDLE: begin
                s_rd_addr = r_old_slot;
                if (s_accept) begin
                    n_cmd = i_in_item;
                    n_ptr = r_old_slot;
                    n_cnt = '0;
                    n_used = '0;
                    n_pend = '0;
                    n_found = 1'b0;
                    case (i_in_item.op)
                        OP_STORE: begin
                            s_wr.we = 1'b1;
                            s_wr.we_marks = 1'b1;
                            s_wr.addr = r_wr_slot;
                            s_wr.stamp = i_in_item.stamp;
                            s_wr.payload = i_in_item.record_payload;
                            n_total = r_total + 32'd1;
                            n_wr_slot = s_wr_next;
                            n_oitem = s_blank;
                            n_oitem.kind = KIND_STORE_ACK;
                            n_oitem.last = 1'b1;
                            if (s_wr_next == r_old_slot) begin
                                n_old_slot = (r_old_slot == SLOTS[SLOT_W-1:0] - 1'b1)
                                             ? '0 : r_old_slot + 1'b1;
                                n_oitem.dropped_oldest = 1'b1;
                            end
                            n_ovalid = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_wr_slot = '0;
                            n_old_slot = '0;
                            n_total = '0;
                            n_oitem = s_blank;
                            n_oitem.kind = KIND_CLEAR_DONE;
                            n_oitem.last = 1'b1;
                            n_ovalid = 1'b1;
                        end
                        OP_UPLOAD, OP_CONFIRM, OP_STATS: begin
                            n_state = ST_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // The slot at r_ptr has been addressed; end of window check.
                s_rd_addr = r_ptr;
                if (r_ptr == r_wr_slot ||
                    (r_cmd.op == OP_UPLOAD && r_cnt >= r_batch)) begin
                    if (r_cmd.op == OP_CONFIRM) begin
                        n_ptr = r_old_slot;
                        n_state = ST_RET;
                    end else begin
                        n_state = ST_FIN;
                    end
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                s_rd_addr = s_ptr_next;
                case (r_cmd.op)
                    OP_UPLOAD: begin
                        if (!s_rd.sent) begin
                            if (s_out_free) begin
                                n_oitem = s_blank;
                                n_oitem.kind = KIND_SENT;
                                n_oitem.out_stamp = s_rd.stamp;
                                n_oitem.out_payload = s_rd.payload;
                                n_ovalid = 1'b1;
                                s_wr.we_marks = 1'b1;
                                s_wr.sent = 1'b1;
                                s_wr.conf = s_rd.conf;
                                n_cnt = r_cnt + 4'd1;
                                n_ptr = s_ptr_next;
                                n_state = ST_WALK;
                            end else begin
                                s_rd_addr = r_ptr;
                            end
                        end else begin
                            n_ptr = s_ptr_next;
                            n_state = ST_WALK;
                        end
                    end
                    OP_CONFIRM: begin
                        if (s_rd.stamp == r_cmd.stamp) begin
                            s_wr.we_marks = 1'b1;
                            s_wr.sent = s_rd.sent;
                            s_wr.conf = 1'b1;
                            n_found = 1'b1;
                            n_ptr = r_old_slot;
                            n_state = ST_RET;
                            s_rd_addr = r_old_slot;
                        end else begin
                            n_ptr = s_ptr_next;
                            n_state = ST_WALK;
                        end
                    end
                    default: begin
                        n_used = r_used + 1'b1;
                        if (!s_rd.conf) begin
                            n_pend = r_pend + 1'b1;
                        end
                        n_ptr = s_ptr_next;
                        n_state = ST_WALK;
                    end
                endcase
            end
            ST_RET: begin
                // The slot is read again here so a confirm write just made is read back.
                s_rd_addr = r_ptr;
                if (r_ptr == r_wr_slot) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_RETE;
                end
            end
            ST_RETE: begin
                s_rd_addr = s_ptr_next;
                if (s_rd.conf) begin
                    n_ptr = s_ptr_next;
                    n_old_slot = s_ptr_next;
                    n_state = ST_RET;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (s_out_free) begin
                    n_oitem = s_blank;
                    n_oitem.last = 1'b1;
                    case (r_cmd.op)
                        OP_UPLOAD: begin
                            n_oitem.kind = KIND_UPLOAD_DONE;
                            n_oitem.sent_count = r_cnt;
                        end
                        OP_CONFIRM: begin
                            n_oitem.kind = KIND_CONFIRM_ACK;
                            n_oitem.found = r_found;
                        end
                        default: begin
                            n_oitem.kind = KIND_STATS;
                            n_oitem.used_slots = r_used[5:0];
                            n_oitem.pending_records = r_pend[5:0];
                            n_oitem.free_records = 7'(SLOTS - int'(r_used));
                            n_oitem.total_stored = r_total;
                        end
                    endcase
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_batch <= BATCH_RESET;
            r_wr_slot <= '0;
            r_old_slot <= '0;
            r_total <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_batch <= i_cfg_data;
            end
            r_wr_slot <= n_wr_slot;
            r_old_slot <= n_old_slot;
            r_total <= n_total;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_ptr <= n_ptr;
        r_cnt <= n_cnt;
        r_used <= n_used;
        r_pend <= n_pend;
        r_found <= n_found;
        r_oitem <= n_oitem;
    end

endmodule

>>> test/acked_circular_record_log_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record log core testbench
// Drives store, upload, confirm, stats and clear operations with random
// idling on both channels and checks every result item against a predictor
// of the ring, its sent and confirmed marks and the batch limit.
// ----------------------------------------------------------------------------
module acked_circular_record_log_core_tb;
    import acrl_pkg::*;

    // Idle gap in cycles allowed before a batch limit write. Confirm walks the
    // window twice, so this covers the longest operation.
    localparam int IDLE_GAP    = 4 * SLOTS + 20;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 300;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [3:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    acked_circular_record_log_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Predictor copy of the ring.
    logic [31:0] ring_stamp [SLOTS];
    logic [63:0] ring_payload [SLOTS];
    logic        ring_sent [SLOTS];
    logic        ring_conf [SLOTS];
    int unsigned wr_slot, old_slot;
    logic [31:0] total_cnt;
    logic [3:0]  batch_lim;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        errors;
    int        result_count;
    int        cycle_count;
    bit        quiet_phase;
    bit        hold_request;

    function automatic int unsigned step_slot(int unsigned s);
        return (s + 1 >= SLOTS) ? 0 : s + 1;
    endfunction

    function automatic int unsigned window_size();
        return (wr_slot + SLOTS - old_slot) % SLOTS;
    endfunction

    // Works out the result items of one accepted operation and advances the
    // predicted ring state.
    task automatic predict_operation(input t_in_item it);
        t_out_item   r;
        int unsigned p;
        int unsigned cnt;
        int unsigned used;
        int unsigned pend;
        r = '0;
        r.last = 1'b1;
        case (it.op)
            OP_STORE: begin
                ring_stamp[wr_slot] = it.stamp;
                ring_payload[wr_slot] = it.record_payload;
                ring_sent[wr_slot] = 1'b0;
                ring_conf[wr_slot] = 1'b0;
                total_cnt = total_cnt + 1;
                wr_slot = step_slot(wr_slot);
                r.kind = KIND_STORE_ACK;
                if (wr_slot == old_slot) begin
                    old_slot = step_slot(old_slot);
                    r.dropped_oldest = 1'b1;
                end
                expected_results.push_back(r);
            end
            OP_UPLOAD: begin
                cnt = 0;
                p = old_slot;
                while (p != wr_slot && cnt < batch_lim) begin
                    if (!ring_sent[p]) begin
                        t_out_item s;
                        s = '0;
                        s.kind = KIND_SENT;
                        s.out_stamp = ring_stamp[p];
                        s.out_payload = ring_payload[p];
                        expected_results.push_back(s);
                        ring_sent[p] = 1'b1;
                        cnt++;
                    end
                    p = step_slot(p);
                end
                r.kind = KIND_UPLOAD_DONE;
                r.sent_count = cnt[3:0];
                expected_results.push_back(r);
            end
            OP_CONFIRM: begin
                p = old_slot;
                while (p != wr_slot) begin
                    if (ring_stamp[p] == it.stamp) begin
                        ring_conf[p] = 1'b1;
                        r.found = 1'b1;
                        break;
                    end
                    p = step_slot(p);
                end
                while (old_slot != wr_slot && ring_conf[old_slot])
                    old_slot = step_slot(old_slot);
                r.kind = KIND_CONFIRM_ACK;
                expected_results.push_back(r);
            end
            OP_STATS: begin
                used = 0;
                pend = 0;
                p = old_slot;
                while (p != wr_slot) begin
                    used++;
                    if (!ring_conf[p])
                        pend++;
                    p = step_slot(p);
                end
                r.kind = KIND_STATS;
                r.used_slots = used[5:0];
                r.pending_records = pend[5:0];
                r.free_records = 7'(SLOTS - used);
                r.total_stored = total_cnt;
                expected_results.push_back(r);
            end
            OP_CLEAR: begin
                wr_slot = 0;
                old_slot = 0;
                total_cnt = '0;
                r.kind = KIND_CLEAR_DONE;
                expected_results.push_back(r);
            end
            default: begin
                // Unknown operations give no result and leave the ring alone.
            end
        endcase
    endtask

    // Driver: offers queued items, with random idle bursts between them.
    int drive_gap;
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            drive_gap <= 0;
        end else begin
            if (in_valid && !in_stall)
                predict_operation(in_item);
            if (in_valid && in_stall) begin
                // Payload is held while the block stalls.
            end else if (drive_gap > 0) begin
                in_valid <= 1'b0;
                drive_gap <= drive_gap - 1;
            end else if (pending_items.size() > 0) begin
                if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                    in_valid <= 1'b0;
                    drive_gap <= $urandom_range(1, 19) - 1;
                end else begin
                    in_valid <= 1'b1;
                    in_item <= pending_items.pop_front();
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks result items and applies stall bursts on the output.
    int stall_left;
    int hold_left;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, out_item);
                    errors++;
                end else begin
                    t_out_item e;
                    e = expected_results.pop_front();
                    if (out_item !== e) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, e, out_item);
                        errors++;
                    end
                end
            end
            if (hold_request && hold_left == 0) begin
                hold_request = 1'b0;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end else if (hold_left > 1) begin
                hold_left <= hold_left - 1;
            end else if (hold_left == 1) begin
                hold_left <= 0;
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_stall <= (stall_left > 1);
            end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
                stall_left <= $urandom_range(1, 19);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic [2:0] op, logic [31:0] st,
                                           logic [63:0] pl);
        t_in_item it;
        it.op = op;
        it.stamp = st;
        it.record_payload = pl;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Waits until every queued item is taken and every result has come back,
    // then lets the block settle before the batch limit is changed.
    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_batch_limit(input logic [3:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        batch_lim = v;
    endtask

    // Random phase: stores most often, uploads, confirms mostly of recent stamps,
    // stats, clears, unknown operations, so records are sent and retired in turn.
    task automatic random_phase(input int count);
        logic [31:0] recent[$];
        logic [31:0] st;
        int          sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                st = $urandom();
                recent.push_back(st);
                if (recent.size() > 80)
                    void'(recent.pop_front());
                pending_items.push_back(make_item(OP_STORE, st, rand64()));
            end else if (sel < 60) begin
                pending_items.push_back(make_item(OP_UPLOAD, $urandom(), rand64()));
            end else if (sel < 82) begin
                if (recent.size() > 0 && $urandom_range(0, 4) != 0)
                    st = recent[$urandom_range(0, recent.size() - 1)];
                else
                    st = $urandom();
                pending_items.push_back(make_item(OP_CONFIRM, st, rand64()));
            end else if (sel < 92) begin
                pending_items.push_back(make_item(OP_STATS, $urandom(), rand64()));
            end else if (sel < 95) begin
                pending_items.push_back(make_item(OP_CLEAR, $urandom(), rand64()));
            end else begin
                pending_items.push_back(make_item(3'($urandom_range(5, 7)),
                                                  $urandom(), rand64()));
            end
        end
    endtask

    initial begin
        errors = 0;
        result_count = 0;
        cycle_count = 0;
        quiet_phase = 1'b0;
        hold_request = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        wr_slot = 0;
        old_slot = 0;
        total_cnt = '0;
        batch_lim = BATCH_RESET;
        for (int s = 0; s < SLOTS; s++) begin
            ring_sent[s] = 1'b0;
            ring_conf[s] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset batch limit: empty ring cases, field
        // extremes, a miss and hits on confirm, unknown operations.
        pending_items.push_back(make_item(OP_STATS, '0, '0));
        pending_items.push_back(make_item(OP_UPLOAD, '0, '0));
        pending_items.push_back(make_item(OP_CONFIRM, '1, '1));
        pending_items.push_back(make_item(OP_STORE, '0, '0));
        pending_items.push_back(make_item(OP_STORE, '1, '1));
        pending_items.push_back(make_item(OP_STORE, 32'h5555_aaaa,
                                          64'haaaa_5555_aaaa_5555));
        pending_items.push_back(make_item(3'd7, '1, '1));
        pending_items.push_back(make_item(3'd5, '0, '0));
        pending_items.push_back(make_item(OP_UPLOAD, '0, '0));
        pending_items.push_back(make_item(OP_CONFIRM, 32'h1234_5678, '0));
        pending_items.push_back(make_item(OP_CONFIRM, '1, '0));
        pending_items.push_back(make_item(OP_CONFIRM, '0, '0));
        pending_items.push_back(make_item(OP_STATS, '0, '0));
        pending_items.push_back(make_item(OP_CLEAR, '0, '0));
        pending_items.push_back(make_item(OP_STATS, '0, '0));
        wait_idle();

        // Batch limit zero: uploads give only the done item.
        write_batch_limit(4'd0);
        pending_items.push_back(make_item(OP_STORE, 32'd1, 64'd1));
        pending_items.push_back(make_item(OP_UPLOAD, '0, '0));
        wait_idle();

        // Largest batch limit, then fill past the ring so that stores drop
        // the oldest record, while the receiver holds off for a long spell.
        write_batch_limit(4'd15);
        hold_request = 1'b1;
        for (int i = 0; i < SLOTS + 4; i++)
            pending_items.push_back(make_item(OP_STORE, 32'(i + 100), rand64()));
        pending_items.push_back(make_item(OP_STATS, '0, '0));
        pending_items.push_back(make_item(OP_UPLOAD, '0, '0));
        random_phase(60);
        wait_idle();

        write_batch_limit(4'd1);
        random_phase(60);
        wait_idle();

        write_batch_limit(4'd7);
        random_phase(60);
        wait_idle();

        // Closing stretch with no idling on either side.
        quiet_phase = 1'b1;
        random_phase(40);
        wait_idle();

        $display("Covered %0d result items over batch limits 10, 0, 15, 1 and 7,",
                 result_count);
        $display("including ring wrap with drops, retirement and a long output hold.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/acrl_pkg.sv
rtl/core/acrl_store.sv
rtl/core/acked_circular_record_log_core.sv
test/acked_circular_record_log_core_tb.sv
